### hw/rtl/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// Shared types and constants for the integer formatter.
// ----------------------------------------------------------------------------
package pif_pkg;

	localparam int MAX_OUT_CHARS = 64;
	localparam int VALUE_BITS    = 64;
	localparam int DIGIT_MAX     = 24;
	localparam int CNT_W         = $clog2(MAX_OUT_CHARS + 1);
	localparam int DIG_W         = $clog2(DIGIT_MAX + 1);

	localparam logic [2:0] OP_SDEC  = 3'd0;
	localparam logic [2:0] OP_UDEC  = 3'd1;
	localparam logic [2:0] OP_HEXL  = 3'd2;
	localparam logic [2:0] OP_HEXU  = 3'd3;
	localparam logic [2:0] OP_OCT   = 3'd4;
	localparam logic [2:0] OP_CHAR  = 3'd5;
	localparam logic [2:0] OP_PCT   = 3'd6;
	localparam logic [2:0] OP_NONE  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PLAN,
		ST_EMIT
	} pif_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic conv_step;
		logic plan;
		logic emit;
	} pif_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic conv_done;
		logic empty;
		logic emit_last;
	} pif_stat_t;

endpackage

### hw/rtl/printf_integer_formatter.sv
// ----------------------------------------------------------------------------
// printf_integer_formatter
// Formats one printf-style integer, character or percent conversion.
// ----------------------------------------------------------------------------
// Usage: drive the request fields and raise start while busy is low; the
// transaction is taken at that edge and busy rises.
// Digits are extracted first: one hex or octal digit per cycle, while each
// decimal digit takes one step per 22-bit chunk (at most 20 decimal digits).
// The conversion state then ends and a plan state lays out the text.
// Characters then follow one per cycle; each is on out_char for one cycle
// with valid high, and last marks the final one.
// busy stays high from the accepting edge until the last character has been
// issued (or an empty request has returned to idle), so a new request is
// taken only after the current one is done. Text is cut at 64 characters.
// Requests that produce no text (operation 7, empty text) give no strobe.
// The receiver cannot stall; characters are simply presented.
// Reset returns the controller to idle at once.
// ----------------------------------------------------------------------------
module printf_integer_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	input  logic [2:0]  operation,
	input  logic        long_size,
	input  logic        plus_sign,
	input  logic        space_sign,
	input  logic        alternate,
	input  logic        zero_pad,
	input  logic        left_justify,
	input  logic [6:0]  field_width,
	input  logic        precision_given,
	input  logic [6:0]  precision,
	output logic        valid,
	output logic [7:0]  out_char,
	output logic        last
);
	import pif_pkg::*;

	pif_cmd_t  cmd;
	pif_stat_t stat;

	pif_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .stat);

	pif_dp u_dp (
		.clk, .value, .operation, .long_size, .plus_sign, .space_sign,
		.alternate, .zero_pad, .left_justify, .field_width,
		.precision_given, .precision, .cmd, .stat, .out_char, .last
	);

	// Strobe is registered: it rises in the cycle after the emit command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid <= 1'b0;
		else valid <= cmd.emit;
	end
endmodule

### hw/rtl/pif_ctrl.sv
// ----------------------------------------------------------------------------
// pif_ctrl
// Sequencer: load, digit conversion, layout planning, character emission.
// ----------------------------------------------------------------------------
module pif_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output pif_pkg::pif_cmd_t cmd,
	input  pif_pkg::pif_stat_t stat
);
	import pif_pkg::*;

	pif_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_done) state_d = ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.emit = 1'b1;
					if (stat.emit_last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hw/rtl/pif_dp.sv
// ----------------------------------------------------------------------------
// pif_dp
// Datapath: captures the request, extracts digits (one per cycle for hex and
// octal, by a chunked division by ten for decimal), then walks the text
// layout one character per cycle.
// ----------------------------------------------------------------------------
module pif_dp (
	input  logic               clk,
	input  logic [63:0]        value,
	input  logic [2:0]         operation,
	input  logic               long_size,
	input  logic               plus_sign,
	input  logic               space_sign,
	input  logic               alternate,
	input  logic               zero_pad,
	input  logic               left_justify,
	input  logic [6:0]         field_width,
	input  logic               precision_given,
	input  logic [6:0]         precision,
	input  pif_pkg::pif_cmd_t  cmd,
	output pif_pkg::pif_stat_t stat,
	output logic [7:0]         out_char,
	output logic               last
);
	import pif_pkg::*;

	logic [2:0]  op_q;
	logic        alt_q, zp_q, left_q, pg_q;
	logic [6:0]  width_q, prec_q;
	logic [7:0]  chr_q;
	logic [63:0] v_q;
	logic        nz_q;
	logic [3:0]  digs_q [DIGIT_MAX];
	logic [DIG_W-1:0] len_q;
	logic        sign_q;
	logic [7:0]  sign_ch_q;

	// Layout segment lengths, computed once at plan time.
	logic [7:0]  lspc_q, zer_q;
	logic        has_sign_q, has_pfx_q;
	logic [7:0]  pos_q;   // position within the walk
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]  total_q;

	// Status toward the controller.
	logic        conv_done, text_empty, emit_last;

	// Decimal step: divide by ten 22 bits at a time, top chunk first, with a
	// reciprocal multiply. The remainder of one chunk carries into the next.
	logic [1:0]  ph_q;
	logic [3:0]  rdec_q;
	logic [43:0] qacc_q;
	logic [21:0] chunk, dq;
	logic [25:0] dx, dsub;
	logic [57:0] dprod;
	logic [65:0] dquo;
	always_comb begin
		case (ph_q)
			2'd0: chunk = {2'd0, v_q[63:44]};
			2'd1: chunk = v_q[43:22];
			default: chunk = v_q[21:0];
		endcase
		dx = {(ph_q == 2'd0) ? 4'd0 : rdec_q, chunk};
		dprod = {32'd0, dx} * {26'd0, 32'hCCCC_CCCD};
		dq = dprod[56:35];
		dsub = dx - ({1'b0, dq, 3'd0} + {3'd0, dq, 1'b0});
		dquo = {qacc_q, dq};
	end

	// Radix step: one digit per cycle, or for decimal a digit in the last chunk phase.
	logic [63:0] quo;
	logic [3:0]  rem;
	logic        dig_ready;
	always_comb begin
		dig_ready = 1'b1;
		case (op_q)
			OP_SDEC, OP_UDEC: begin
				quo = dquo[63:0];
				rem = dsub[3:0];
				dig_ready = (ph_q == 2'd2);
			end
			OP_OCT: begin quo = v_q >> 3; rem = {1'b0, v_q[2:0]}; end
			default: begin quo = v_q >> 4; rem = v_q[3:0]; end
		endcase
	end

	logic [VALUE_BITS-1:0] mag;
	logic neg;
	always_comb begin
		mag = long_size ? value[VALUE_BITS-1:0] : {32'd0, value[31:0]};
		neg = (operation == OP_SDEC) &&
			(long_size ? value[VALUE_BITS-1] : value[31]);
		if (neg) mag = long_size ? (~mag + 64'd1) : {32'd0, ~value[31:0] + 32'd1};
	end

	assign conv_done = (v_q == 64'd0) || (len_q == DIG_W'(DIGIT_MAX));

	// Plan arithmetic.
	logic [7:0] ndig, body, zeros, tot, spc, eprec;
	logic       zact, is_int, pfx;
	always_comb begin
		is_int = (op_q != OP_CHAR) && (op_q != OP_PCT);
		eprec = pg_q ? {1'b0, prec_q} : 8'd1;
		ndig = (eprec > 8'(len_q)) ? eprec : 8'(len_q);
		if (op_q == OP_OCT && alt_q && ndig <= 8'(len_q)) ndig = 8'(len_q) + 8'd1;
		pfx = (op_q == OP_HEXL || op_q == OP_HEXU) && alt_q && nz_q;
		if (!is_int) ndig = 8'd1;
		body = {7'd0, sign_q} + (pfx ? 8'd2 : 8'd0) + ndig;
		zact = zp_q && !left_q && (is_int ? !pg_q : (op_q == OP_CHAR));
		zeros = (zact && {1'b0, width_q} > body) ? {1'b0, width_q} - body : 8'd0;
		tot = body + zeros;
		spc = ({1'b0, width_q} > tot) ? {1'b0, width_q} - tot : 8'd0;
		zeros = is_int ? zeros + (ndig - 8'(len_q)) : zeros;
	end

	// Current character from position.
	logic [7:0] p, ch, dch, e0, e1, e2, e3;
	logic [3:0] dv;
	logic [DIG_W-1:0] di;
	logic [7:0] dofs;
	always_comb begin
		p = pos_q;
		e0 = lspc_q;
		e1 = e0 + {7'd0, has_sign_q};
		e2 = e1 + (has_pfx_q ? 8'd2 : 8'd0);
		e3 = e2 + zer_q;
		dofs = p - e3;
		di = DIG_W'(8'(len_q) - 8'd1 - dofs);
		dv = digs_q[di[4:0] < 5'(DIGIT_MAX) ? di[4:0] : 5'd0];
		dch = (dv < 4'd10) ? 8'd48 + {4'd0, dv}
			: ((op_q == OP_HEXU) ? 8'd65 : 8'd97) + {4'd0, dv} - 8'd10;
		if (p < e0) ch = 8'h20;
		else if (p < e1) ch = sign_ch_q;
		else if (p < e2) ch = (p == e1) ? 8'h30 : ((op_q == OP_HEXU) ? 8'h58 : 8'h78);
		else if (p < e3) ch = 8'h30;
		else if (op_q == OP_CHAR) ch = (p == e3) ? chr_q : 8'h20;
		else if (op_q == OP_PCT) ch = (p == e3) ? 8'h25 : 8'h20;
		else if (dofs < 8'(len_q)) ch = dch;
		else ch = 8'h20;
	end

	assign text_empty = (total_q == 8'd0) || (op_q == OP_NONE);
	assign emit_last = ({1'b0, pos_q} + 9'd1 == {1'b0, total_q}) ||
		(cnt_q == CNT_W'(MAX_OUT_CHARS - 1));

	assign stat = '{conv_done: conv_done, empty: text_empty, emit_last: emit_last};

	// Registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation; alt_q <= alternate; zp_q <= zero_pad;
			left_q <= left_justify; pg_q <= precision_given; prec_q <= precision;
			width_q <= field_width; chr_q <= value[7:0];
			v_q <= (operation == OP_CHAR || operation == OP_PCT) ? 64'd0 : mag;
			nz_q <= (mag != 64'd0);
			len_q <= '0;
			ph_q <= 2'd0;
			sign_q <= neg || (operation == OP_SDEC && (plus_sign || space_sign));
			sign_ch_q <= neg ? 8'h2d : (plus_sign ? 8'h2b : 8'h20);
		end
		if (cmd.conv_step && !conv_done) begin
			if (dig_ready) begin
				digs_q[len_q[4:0]] <= rem;
				len_q <= len_q + DIG_W'(1);
				v_q <= quo;
				ph_q <= 2'd0;
			end else begin
				ph_q <= ph_q + 2'd1;
				rdec_q <= dsub[3:0];
				qacc_q <= {qacc_q[21:0], dq};
			end
		end
		if (cmd.plan) begin
			has_sign_q <= sign_q && is_int;
			has_pfx_q <= pfx;
			zer_q <= zeros;
			lspc_q <= left_q ? 8'd0 : spc;
			total_q <= (op_q == OP_NONE) ? 8'd0 : tot + spc;
			pos_q <= 8'd0;
			cnt_q <= '0;
		end
		if (cmd.emit) begin
			pos_q <= pos_q + 8'd1;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Output register: one character per strobe.
	always_ff @(posedge clk) begin
		out_char <= ch;
		last <= emit_last;
	end
endmodule
